[design/dxsd_pkg.sv]
// shared types, constants and substitution table for the datagram deobfuscator
package dxsd_pkg;

  // mask applied to each decoded byte before it enters the running sum
  localparam logic [7:0] SumMask = 8'hAA;

  // one accepted datagram byte with its position tags
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       first;
    logic       odd;
  } dxsd_item_t;

  // byte substitution rom
  localparam logic [7:0] Sbox [256] = '{
    8'h34, 8'h1E, 8'h45, 8'hB0, 8'h03, 8'hD2, 8'hA2, 8'h7B,
    8'h3E, 8'h1D, 8'hE8, 8'hFC, 8'hAD, 8'hAC, 8'h35, 8'h27,
    8'hD7, 8'h0E, 8'h0F, 8'h63, 8'hB8, 8'h68, 8'h22, 8'hEC,
    8'h7E, 8'h14, 8'h3B, 8'h52, 8'hDB, 8'h81, 8'h15, 8'h70,
    8'hA6, 8'h2F, 8'h4C, 8'hB3, 8'hDD, 8'h64, 8'h91, 8'h95,
    8'h49, 8'h0A, 8'hF7, 8'h83, 8'h39, 8'hF8, 8'h07, 8'h88,
    8'hA5, 8'h0C, 8'h72, 8'h4D, 8'h8F, 8'hB9, 8'hB4, 8'h86,
    8'hFE, 8'hB7, 8'h31, 8'hE7, 8'hEE, 8'h73, 8'h00, 8'hF2,
    8'h69, 8'hE3, 8'h29, 8'hD8, 8'h4E, 8'h2E, 8'h12, 8'h55,
    8'h5C, 8'hF5, 8'h5D, 8'hF3, 8'hCE, 8'h5E, 8'hA7, 8'hCF,
    8'h5B, 8'hCD, 8'hE0, 8'h24, 8'hC1, 8'h08, 8'h06, 8'h1A,
    8'h82, 8'hFD, 8'hB1, 8'h3F, 8'h0D, 8'h30, 8'hBC, 8'h9D,
    8'hD6, 8'h11, 8'h7C, 8'hD5, 8'hA1, 8'h93, 8'h84, 8'h78,
    8'hCC, 8'hF1, 8'hA3, 8'hF0, 8'h28, 8'hB6, 8'h02, 8'h96,
    8'hA0, 8'h1B, 8'h59, 8'hF9, 8'h04, 8'h7D, 8'hA4, 8'h46,
    8'h8B, 8'h8C, 8'h5F, 8'hC7, 8'h7F, 8'h26, 8'h6A, 8'h80,
    8'h60, 8'h79, 8'h17, 8'hFF, 8'hF6, 8'hFB, 8'h71, 8'hDA,
    8'h09, 8'h9B, 8'h0B, 8'hA8, 8'hBD, 8'h10, 8'hAE, 8'h3D,
    8'hD1, 8'h9A, 8'hB2, 8'h61, 8'h37, 8'hED, 8'hE1, 8'h9F,
    8'h18, 8'h7A, 8'h36, 8'hC5, 8'h2B, 8'h90, 8'h8E, 8'hCA,
    8'h87, 8'h44, 8'h43, 8'hEF, 8'h62, 8'h99, 8'h1F, 8'hF4,
    8'h25, 8'h85, 8'hFA, 8'h54, 8'hAA, 8'hE6, 8'h98, 8'h8D,
    8'h77, 8'hE5, 8'h57, 8'h4B, 8'h5A, 8'h56, 8'h9E, 8'h58,
    8'h51, 8'h47, 8'h4F, 8'hDC, 8'hAF, 8'h01, 8'h21, 8'h2D,
    8'h23, 8'hAB, 8'hC4, 8'h16, 8'h97, 8'h3C, 8'h66, 8'hCB,
    8'h4A, 8'hEB, 8'h2A, 8'h76, 8'hBE, 8'h67, 8'h05, 8'h1C,
    8'h6E, 8'hD3, 8'h33, 8'hC2, 8'h75, 8'hD4, 8'h6B, 8'hBA,
    8'h41, 8'h32, 8'h89, 8'h6F, 8'h3A, 8'hE2, 8'h38, 8'hE9,
    8'hE4, 8'h53, 8'h40, 8'hD0, 8'h6C, 8'h42, 8'hBF, 8'hC6,
    8'hB5, 8'hEA, 8'h2C, 8'hC8, 8'h20, 8'hDE, 8'h65, 8'hA9,
    8'h74, 8'h19, 8'h13, 8'hDF, 8'h9C, 8'h8A, 8'h6D, 8'h48,
    8'h92, 8'h94, 8'hD9, 8'hC3, 8'hC9, 8'hBB, 8'hC0, 8'h50
  };

endpackage

[design/dxsd_front.sv]
// input register stage: captures each byte and tags its datagram position
module dxsd_front import dxsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       item_valid_o,
  output dxsd_item_t item_o,
  input  logic       item_take_i
);

  logic       valid_q, valid_d;
  logic       at_start_q, at_start_d;
  logic       odd_q, odd_d;
  dxsd_item_t item_q;
  logic       accept;

  // stage is free when empty or when its item moves on this cycle
  assign in_ready_o = !valid_q || item_take_i;
  assign accept     = in_valid_i && in_ready_o;

  // position tracking for the next byte
  always_comb begin
    valid_d    = valid_q;
    at_start_d = at_start_q;
    odd_d      = odd_q;
    if (item_take_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d    = 1'b1;
      at_start_d = last_byte_i;
      if (at_start_q || last_byte_i) begin
        odd_d = 1'b0;
      end else begin
        odd_d = !odd_q;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      at_start_q <= 1'b1;
      odd_q      <= 1'b0;
    end else begin
      valid_q    <= valid_d;
      at_start_q <= at_start_d;
      odd_q      <= odd_d;
    end
  end

  // item payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.data  <= in_byte_i;
      item_q.last  <= last_byte_i;
      item_q.first <= at_start_q;
      item_q.odd   <= odd_q;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

[design/dxsd_back.sv]
// decode stage: key xor (skipped for odd-tagged bytes), sbox lookup, checksum accumulate, result register
module dxsd_back import dxsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  input  dxsd_item_t item_i,
  output logic       item_take_o,
  input  logic [7:0] port_key_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] decoded_byte_o,
  output logic       has_data_o,
  output logic       end_of_packet_o,
  output logic       checksum_ok_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] running_sum_q, running_sum_d;
  logic [7:0] expected_q, expected_d;
  logic [7:0] decoded_q, decoded_d;
  logic       has_data_q, has_data_d;
  logic       eop_q, eop_d;
  logic       ok_q, ok_d;
  logic [7:0] keyed;
  logic [7:0] sub;
  logic [7:0] sum_next;
  logic       no_result;
  logic       out_free;
  logic       take;

  // a checksum byte that is not last yields nothing
  assign no_result   = item_i.first && !item_i.last;
  assign out_free    = !out_valid_q || out_ready_i;
  assign take        = item_valid_i && (no_result || out_free);
  assign item_take_o = take;

  // decode datapath
  assign keyed    = item_i.odd ? item_i.data : (item_i.data ^ port_key_i);
  assign sub      = Sbox[keyed];
  assign sum_next = running_sum_q + (sub & SumMask);

  always_comb begin
    out_valid_d   = out_valid_q;
    running_sum_d = running_sum_q;
    expected_d    = expected_q;
    decoded_d     = decoded_q;
    has_data_d    = has_data_q;
    eop_d         = eop_q;
    ok_d          = ok_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (take) begin
      if (item_i.first) begin
        // checksum byte: latch expected sum, start a fresh sum
        expected_d    = item_i.data;
        running_sum_d = 8'h00;
        if (item_i.last) begin
          out_valid_d = 1'b1;
          decoded_d   = 8'h00;
          has_data_d  = 1'b0;
          eop_d       = 1'b1;
          ok_d        = (item_i.data == 8'h00);
        end
      end else begin
        // payload byte
        out_valid_d   = 1'b1;
        decoded_d     = sub;
        has_data_d    = 1'b1;
        eop_d         = item_i.last;
        ok_d          = item_i.last && (sum_next == expected_q);
        running_sum_d = item_i.last ? 8'h00 : sum_next;
      end
    end
  end

  // control and checksum state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      running_sum_q <= 8'h00;
      expected_q    <= 8'h00;
    end else begin
      out_valid_q   <= out_valid_d;
      running_sum_q <= running_sum_d;
      expected_q    <= expected_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    decoded_q  <= decoded_d;
    has_data_q <= has_data_d;
    eop_q      <= eop_d;
    ok_q       <= ok_d;
  end

  assign out_valid_o     = out_valid_q;
  assign decoded_byte_o  = decoded_q;
  assign has_data_o      = has_data_q;
  assign end_of_packet_o = eop_q;
  assign checksum_ok_o   = ok_q;

endmodule

[design/datagram_xor_sbox_deobfuscator.sv]
// top level of the datagram byte deobfuscator with checksum check
//
//   channel | signals                        | direction | width
//   --------+--------------------------------+-----------+------------------
//   in      | in_valid_i / in_ready_o        | input     | in_byte 8, last 1
//   out     | out_valid_o / out_ready_i      | output    | 8 + 1 + 1 + 1
//   cfg     | cfg_valid_i / cfg_ready_o      | input     | port_key 8
//
// one item per cycle sustained while the output is not stalled; each item
// passes the input register, then is decoded into the result register.
// a checksum byte that is not the last byte gives no result.
// reset returns to expecting a checksum byte, with the xor key cleared.
// a stalled output backs up through the input register to in_ready_o.
module datagram_xor_sbox_deobfuscator import dxsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] decoded_byte_o,
  output logic       has_data_o,
  output logic       end_of_packet_o,
  output logic       checksum_ok_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_port_key_i
);

  logic       port_key_q;
  logic [7:0] key_q;
  dxsd_item_t item;
  logic       item_valid;
  logic       item_take;

  // key register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= 8'h00;
      port_key_q <= 1'b0;
    end else if (cfg_valid_i) begin
      key_q      <= cfg_port_key_i;
      port_key_q <= 1'b1;
    end
  end

  dxsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .last_byte_i  (last_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  dxsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .item_take_o     (item_take),
    .port_key_i      (port_key_q ? key_q : 8'h00),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .decoded_byte_o  (decoded_byte_o),
    .has_data_o      (has_data_o),
    .end_of_packet_o (end_of_packet_o),
    .checksum_ok_o   (checksum_ok_o)
  );

endmodule

[design/dxsd_checker.sv]
// port-level checks on the deobfuscator output, bound to the top level
module dxsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] decoded_byte_o,
  input logic       has_data_o,
  input logic       end_of_packet_o,
  input logic       checksum_ok_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(decoded_byte_o)
      && $stable(end_of_packet_o) && $stable(checksum_ok_o))
    else $error("result item changed while stalled");

  // an item without payload is only the empty datagram verdict
  a_empty_is_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_data_o |-> end_of_packet_o && decoded_byte_o == 8'h00)
    else $error("empty result not marked end of packet");

  // checksum verdict only on the last item
  a_ok_at_eop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_packet_o |-> !checksum_ok_o)
    else $error("checksum ok outside end of packet");

  // no result item straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result item right after reset");

endmodule

bind datagram_xor_sbox_deobfuscator dxsd_checker u_dxsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .decoded_byte_o  (decoded_byte_o),
  .has_data_o      (has_data_o),
  .end_of_packet_o (end_of_packet_o),
  .checksum_ok_o   (checksum_ok_o)
);
